// ===== src/mbus_rx_pkg.sv =====
// Shared types and constants for the M-Bus reply receiver.
// No dependencies; imported by the core, the top level and the checker.
`timescale 1ns / 1ps
`default_nettype none

package mbus_rx_pkg;

  localparam int INDEX_W   = 9;
  localparam int BYTE_W    = 8;
  localparam int TICK_W    = 10;
  localparam int KIND_W    = 2;
  localparam int CAUSE_W   = 3;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 10;

  localparam logic [BYTE_W-1:0] ACK_BYTE   = 8'hE5;
  localparam logic [BYTE_W-1:0] START_BYTE = 8'h68;
  localparam logic [BYTE_W-1:0] STOP_BYTE  = 8'h16;

  localparam logic [INDEX_W-1:0] BUFFER_LIMIT_RESET = 9'd261;
  localparam logic [TICK_W-1:0]  TIMEOUT_RESET      = 10'd500;

  // Item kinds
  localparam logic [KIND_W-1:0] KIND_BYTE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TICK = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ARM  = 2'd2;

  // Error causes
  localparam logic [CAUSE_W-1:0] CAUSE_NONE     = 3'd0;
  localparam logic [CAUSE_W-1:0] CAUSE_LENGTH   = 3'd1;
  localparam logic [CAUSE_W-1:0] CAUSE_START    = 3'd2;
  localparam logic [CAUSE_W-1:0] CAUSE_CHECKSUM = 3'd3;
  localparam logic [CAUSE_W-1:0] CAUSE_STOP     = 3'd4;
  localparam logic [CAUSE_W-1:0] CAUSE_TIMEOUT  = 3'd5;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_LIMIT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT      = 1'd1;

  typedef struct packed {
    logic                 store_valid;
    logic [INDEX_W-1:0]   store_index;
    logic [BYTE_W-1:0]    store_byte;
    logic                 done_res;
    logic                 frame_good;
    logic                 is_ack;
    logic [CAUSE_W-1:0]   error_cause;
  } result_t;

endpackage

`default_nettype wire

// ===== src/mbus_rx_core.sv =====
// Reply state and per-item frame decode for the M-Bus receiver.
// Depends on mbus_rx_pkg; state advances only when step is high.
`timescale 1ns / 1ps
`default_nettype none

module mbus_rx_core import mbus_rx_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               step,
  input  wire logic [KIND_W-1:0]  kind,
  input  wire logic [BYTE_W-1:0]  rx_byte,
  input  wire logic [INDEX_W-1:0] buffer_limit,
  input  wire logic [TICK_W-1:0]  timeout_ticks,
  output logic                    has_result,
  output result_t                 result
);

  logic               armed, armed_next;
  logic [INDEX_W-1:0] position, position_next;
  logic [BYTE_W-1:0]  frame_length, frame_length_next;
  logic [BYTE_W-1:0]  running_sum, running_sum_next;
  logic [TICK_W-1:0]  idle_count, idle_count_next;

  logic [TICK_W:0]    tick_count;
  logic [INDEX_W-1:0] check_at;
  logic [INDEX_W-1:0] stop_at;
  logic [CAUSE_W-1:0] cause;
  logic               good;

  assign tick_count = {1'b0, idle_count} + {{TICK_W{1'b0}}, 1'b1};
  assign check_at   = {1'b0, frame_length} + INDEX_W'(4);
  assign stop_at    = {1'b0, frame_length} + INDEX_W'(5);

  always_comb begin
    armed_next        = armed;
    position_next     = position;
    frame_length_next = frame_length;
    running_sum_next  = running_sum;
    idle_count_next   = idle_count;
    has_result        = 1'b0;
    result            = '0;
    cause             = CAUSE_NONE;
    good              = 1'b0;

    case (kind)
      KIND_ARM: begin
        armed_next        = 1'b1;
        position_next     = '0;
        frame_length_next = '0;
        running_sum_next  = '0;
        idle_count_next   = '0;
      end
      KIND_TICK: begin
        if (armed) begin
          if (tick_count > {1'b0, timeout_ticks}) begin
            armed_next         = 1'b0;
            has_result         = 1'b1;
            result.done_res    = 1'b1;
            result.error_cause = CAUSE_TIMEOUT;
          end else begin
            idle_count_next = tick_count[TICK_W-1:0];
          end
        end
      end
      KIND_BYTE: begin
        if (!armed) begin
          // ignore bytes outside a reply
        end else if (position == '0 && rx_byte != ACK_BYTE && rx_byte != START_BYTE) begin
          // drop hunting noise, idle count keeps running
        end else if (position > buffer_limit) begin
          armed_next         = 1'b0;
          has_result         = 1'b1;
          result.done_res    = 1'b1;
          result.error_cause = CAUSE_STOP;
        end else if (position == '0 && rx_byte == ACK_BYTE) begin
          idle_count_next    = '0;
          armed_next         = 1'b0;
          has_result         = 1'b1;
          result.store_valid = 1'b1;
          result.store_byte  = rx_byte;
          result.done_res    = 1'b1;
          result.frame_good  = 1'b1;
          result.is_ack      = 1'b1;
        end else begin
          idle_count_next = '0;
          if (position == INDEX_W'(1)) begin
            frame_length_next = rx_byte;
          end else if (position == INDEX_W'(2)) begin
            if (rx_byte != frame_length) cause = CAUSE_LENGTH;
          end else if (position == INDEX_W'(3)) begin
            if (rx_byte != START_BYTE) cause = CAUSE_START;
          end else if (position >= INDEX_W'(4)) begin
            if (position < check_at) begin
              running_sum_next = running_sum + rx_byte;
            end else if (position == check_at) begin
              if (rx_byte != running_sum) cause = CAUSE_CHECKSUM;
            end else if (position == stop_at) begin
              if (rx_byte == STOP_BYTE) good = 1'b1;
              else cause = CAUSE_STOP;
            end
          end
          if (good || cause != CAUSE_NONE) armed_next = 1'b0;
          position_next      = position + INDEX_W'(1);
          has_result         = 1'b1;
          result.store_valid = 1'b1;
          result.store_index = position;
          result.store_byte  = rx_byte;
          result.done_res    = good || (cause != CAUSE_NONE);
          result.frame_good  = good;
          result.error_cause = cause;
        end
      end
      default: begin
        // unused kind: no effect
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      armed        <= 1'b0;
      position     <= '0;
      frame_length <= '0;
      running_sum  <= '0;
      idle_count   <= '0;
    end else if (step) begin
      armed        <= armed_next;
      position     <= position_next;
      frame_length <= frame_length_next;
      running_sum  <= running_sum_next;
      idle_count   <= idle_count_next;
    end
  end

endmodule

`default_nettype wire

// ===== src/mbus_response_frame_receiver.sv =====
// Channel     | Dir | Handshake            | Payload
// input item  | in  | in_valid / in_ready  | kind, rx_byte
// result item | out | out_valid / out_ready| store_*, done_res, frame_good, is_ack, error_cause
// config      | in  | cfg_write            | cfg_index, cfg_data
//
// One item per cycle while the result side is not stalled: input register, then decode into the result register.
// An item's result is registered in the result register once the item has left the input register.
// Synchronous reset clears the reply state, config to defaults, both valids.
// A stalled result holds the result register and the item behind it in the
// input register, so input ready drops only when both registers are full.
// Top level of the M-Bus reply receiver; depends on mbus_rx_pkg, mbus_rx_core.
`timescale 1ns / 1ps
`default_nettype none

module mbus_response_frame_receiver import mbus_rx_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [KIND_W-1:0]     kind,
  input  wire logic [BYTE_W-1:0]     rx_byte,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic                       store_valid,
  output logic [INDEX_W-1:0]         store_index,
  output logic [BYTE_W-1:0]          store_byte,
  output logic                       done_res,
  output logic                       frame_good,
  output logic                       is_ack,
  output logic [CAUSE_W-1:0]         error_cause,
  input  wire logic                  cfg_write,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  logic [INDEX_W-1:0] buffer_limit;
  logic [TICK_W-1:0]  timeout_ticks;

  logic              item_valid;
  logic [KIND_W-1:0] item_kind;
  logic [BYTE_W-1:0] item_byte;

  logic    step;
  logic    has_result;
  result_t result;
  result_t out_q;

  assign step     = item_valid && (!out_valid || out_ready);
  assign in_ready = !item_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_limit  <= BUFFER_LIMIT_RESET;
      timeout_ticks <= TIMEOUT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_BUFFER_LIMIT: buffer_limit  <= cfg_data[INDEX_W-1:0];
        CFG_TIMEOUT:      timeout_ticks <= cfg_data[TICK_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_kind <= kind;
      item_byte <= rx_byte;
    end
  end

  mbus_rx_core u_core (
    .clk           (clk),
    .rst           (rst),
    .step          (step),
    .kind          (item_kind),
    .rx_byte       (item_byte),
    .buffer_limit  (buffer_limit),
    .timeout_ticks (timeout_ticks),
    .has_result    (has_result),
    .result        (result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= has_result;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && has_result) begin
      out_q <= result;
    end
  end

  assign store_valid = out_q.store_valid;
  assign store_index = out_q.store_index;
  assign store_byte  = out_q.store_byte;
  assign done_res    = out_q.done_res;
  assign frame_good  = out_q.frame_good;
  assign is_ack      = out_q.is_ack;
  assign error_cause = out_q.error_cause;

endmodule

`default_nettype wire

// ===== src/mbus_rx_checker.sv =====
// Port-level checks for the M-Bus reply receiver, bound to the top level.
// Depends on mbus_rx_pkg and mbus_response_frame_receiver.
`timescale 1ns / 1ps
`default_nettype none

module mbus_rx_checker import mbus_rx_pkg::*; (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic               store_valid,
  input wire logic [INDEX_W-1:0] store_index,
  input wire logic [BYTE_W-1:0]  store_byte,
  input wire logic               done_res,
  input wire logic               frame_good,
  input wire logic               is_ack,
  input wire logic [CAUSE_W-1:0] error_cause
);

  // a stalled result transfer holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(store_index) && $stable(store_byte)
      && $stable(error_cause) && $stable(done_res))
    else $error("stalled result changed");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && !done_res |-> store_valid && !frame_good && !is_ack
      && error_cause == CAUSE_NONE)
    else $error("status set on unfinished reply");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && is_ack |-> frame_good && store_valid && store_index == '0
      && store_byte == ACK_BYTE)
    else $error("bad acknowledge result");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_good && !is_ack |-> store_valid && store_byte == STOP_BYTE
      && error_cause == CAUSE_NONE)
    else $error("good frame without stop byte");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && !store_valid |-> done_res && store_index == '0 && store_byte == '0
      && (error_cause == CAUSE_STOP || error_cause == CAUSE_TIMEOUT))
    else $error("unstored result without overrun or timeout");

endmodule

bind mbus_response_frame_receiver mbus_rx_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .store_valid (store_valid),
  .store_index (store_index),
  .store_byte  (store_byte),
  .done_res    (done_res),
  .frame_good  (frame_good),
  .is_ack      (is_ack),
  .error_cause (error_cause)
);

`default_nettype wire

// ===== tb/mbus_reply_scoreboard.sv =====
// Reply predictor and result scoreboard for the M-Bus reply receiver bench.
// Depends on mbus_rx_pkg for field widths, item kinds, causes and bytes.
`timescale 1ns / 1ps

package mbus_reply_check_pkg;
  import mbus_rx_pkg::*;

  class reply_scoreboard;
    logic [INDEX_W-1:0] buffer_limit;
    logic [TICK_W-1:0]  timeout_ticks;
    bit                 armed;
    logic [INDEX_W-1:0] position;
    logic [BYTE_W-1:0]  frame_length;
    logic [BYTE_W-1:0]  running_sum;
    logic [TICK_W-1:0]  idle_count;
    result_t            expected_replies[$];
    int                 errors;
    int                 accepted_items;

    function new();
      buffer_limit   = BUFFER_LIMIT_RESET;
      timeout_ticks  = TIMEOUT_RESET;
      armed          = 1'b0;
      position       = '0;
      frame_length   = '0;
      running_sum    = '0;
      idle_count     = '0;
      errors         = 0;
      accepted_items = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_BUFFER_LIMIT) begin
        buffer_limit = data[INDEX_W-1:0];
      end else if (idx == CFG_TIMEOUT) begin
        timeout_ticks = data[TICK_W-1:0];
      end
    endfunction

    function int pending();
      return expected_replies.size();
    endfunction

    // Advance the reply state by one accepted item; queue the result it causes.
    function void note_input(logic [KIND_W-1:0] k, logic [BYTE_W-1:0] b);
      result_t            r;
      int                 n;
      int                 idx;
      int                 check_at;
      logic [CAUSE_W-1:0] cause;
      r = '0;
      cause = CAUSE_NONE;
      accepted_items++;
      if (k == KIND_ARM) begin
        armed        = 1'b1;
        position     = '0;
        frame_length = '0;
        running_sum  = '0;
        idle_count   = '0;
        return;
      end
      if ((k != KIND_BYTE && k != KIND_TICK) || !armed) return;
      if (k == KIND_TICK) begin
        n = int'(idle_count) + 1;
        if (n > timeout_ticks) begin
          armed = 1'b0;
          r.done_res = 1'b1;
          r.error_cause = CAUSE_TIMEOUT;
          expected_replies.push_back(r);
        end else begin
          idle_count = n[TICK_W-1:0];
        end
        return;
      end
      // drop noise while hunting; the idle count keeps running
      if (position == 0 && b != ACK_BYTE && b != START_BYTE) return;
      if (position > buffer_limit) begin
        armed = 1'b0;
        r.done_res = 1'b1;
        r.error_cause = CAUSE_STOP;
        expected_replies.push_back(r);
        return;
      end
      idx = int'(position);
      idle_count = '0;
      r.store_valid = 1'b1;
      r.store_index = position;
      r.store_byte  = b;
      if (idx == 0 && b == ACK_BYTE) begin
        armed = 1'b0;
        r.done_res = 1'b1;
        r.frame_good = 1'b1;
        r.is_ack = 1'b1;
        expected_replies.push_back(r);
        return;
      end
      check_at = int'(frame_length) + 4;
      if (idx == 1) begin
        frame_length = b;
      end else if (idx == 2) begin
        if (b != frame_length) cause = CAUSE_LENGTH;
      end else if (idx == 3) begin
        if (b != START_BYTE) cause = CAUSE_START;
      end else if (idx >= 4) begin
        if (idx < check_at) begin
          running_sum = running_sum + b;
        end else if (idx == check_at) begin
          if (b != running_sum) cause = CAUSE_CHECKSUM;
        end else if (idx == check_at + 1) begin
          if (b == STOP_BYTE) begin
            r.done_res = 1'b1;
            r.frame_good = 1'b1;
          end else begin
            cause = CAUSE_STOP;
          end
        end
      end
      if (cause != CAUSE_NONE) r.done_res = 1'b1;
      r.error_cause = cause;
      if (r.done_res) armed = 1'b0;
      position = position + 1'b1;
      expected_replies.push_back(r);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 40) $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    task compare_field(string name, int got, int want);
      if (got != want) report($sformatf("%s got %0d, want %0d", name, got, want));
    endtask

    // Compare one result transfer with the oldest queued reply result.
    task check_result(result_t got);
      result_t want;
      if (expected_replies.size() == 0) begin
        report($sformatf("result with nothing queued: %p", got));
        return;
      end
      want = expected_replies.pop_front();
      if ($isunknown(got)) report($sformatf("unknown bits in result: %p", got));
      compare_field("store_valid", int'(got.store_valid), int'(want.store_valid));
      compare_field("store_index", int'(got.store_index), int'(want.store_index));
      compare_field("store_byte", int'(got.store_byte), int'(want.store_byte));
      compare_field("done_res", int'(got.done_res), int'(want.done_res));
      compare_field("frame_good", int'(got.frame_good), int'(want.frame_good));
      compare_field("is_ack", int'(got.is_ack), int'(want.is_ack));
      compare_field("error_cause", int'(got.error_cause), int'(want.error_cause));
    endtask
  endclass

endpackage

// ===== tb/testbench.sv =====
// Top-level bench for mbus_response_frame_receiver: drives replies, noise and
// register settings, and checks every result through reply_scoreboard.
// Depends on mbus_rx_pkg, mbus_reply_check_pkg and the receiver RTL.
`timescale 1ns / 1ps

module testbench;
  import mbus_rx_pkg::*;
  import mbus_reply_check_pkg::*;

  localparam int SETTLE_CYCLES = 6;
  localparam int ITEM_TARGET   = 780;

  typedef enum int {
    REPLY_CLEAN,
    REPLY_BAD_LENGTH,
    REPLY_BAD_START,
    REPLY_BAD_CHECKSUM,
    REPLY_BAD_STOP,
    REPLY_ACK,
    REPLY_SILENT
  } reply_shape_t;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  logic [KIND_W-1:0]     kind      = KIND_BYTE;
  logic [BYTE_W-1:0]     rx_byte   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  store_valid;
  logic [INDEX_W-1:0]    store_index;
  logic [BYTE_W-1:0]     store_byte;
  logic                  done_res;
  logic                  frame_good;
  logic                  is_ack;
  logic [CAUSE_W-1:0]    error_cause;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_BUFFER_LIMIT;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  reply_scoreboard sb;
  bit              sender_calm  = 1'b0;
  bit              rx_calm      = 1'b0;
  bit              hold_request = 1'b0;
  int              stall_left   = 0;
  int              mode_left    = 0;
  int              cur_timeout  = int'(TIMEOUT_RESET);
  int              phase;
  int              final_wait;
  int              len;
  result_t         got;

  mbus_response_frame_receiver u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .kind        (kind),
    .rx_byte     (rx_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .store_valid (store_valid),
    .store_index (store_index),
    .store_byte  (store_byte),
    .done_res    (done_res),
    .frame_good  (frame_good),
    .is_ack      (is_ack),
    .error_cause (error_cause),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
  endfunction

  // Result side: random stalls, calm stretches, and one long hold on request.
  always @(posedge clk) begin
    if (hold_request) begin
      hold_request = 1'b0;
      stall_left = 400;
    end
    if (mode_left == 0) begin
      rx_calm = ($urandom_range(0, 2) == 0);
      mode_left = $urandom_range(50, 200);
    end else begin
      mode_left--;
    end
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else if (!rx_calm && $urandom_range(0, 4) == 0) begin
      out_ready <= 1'b0;
      stall_left = pick_gap() - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Sample both channels on the edge that completes each transfer.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        got.store_valid = store_valid;
        got.store_index = store_index;
        got.store_byte  = store_byte;
        got.done_res    = done_res;
        got.frame_good  = frame_good;
        got.is_ack      = is_ack;
        got.error_cause = error_cause;
        sb.check_result(got);
      end
      if (in_valid && in_ready) sb.note_input(kind, rx_byte);
    end
  end

  // Offer one item and hold it until the transfer; valid stays up unless a gap follows.
  task automatic send_item(input logic [KIND_W-1:0] k, input logic [BYTE_W-1:0] b);
    int gap;
    in_valid <= 1'b1;
    kind     <= k;
    rx_byte  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    gap = (!sender_calm && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    if ($urandom_range(0, 7) == 0) send_item(KIND_TICK, BYTE_W'($urandom));
    send_item(KIND_BYTE, b);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_write <= 1'b0;
    sb.set_register(idx, value[CFG_DATA_W-1:0]);
    @(posedge clk);
  endtask

  task automatic configure(input int limit, input int ticks);
    drain();
    write_reg(CFG_BUFFER_LIMIT, limit);
    write_reg(CFG_TIMEOUT, ticks);
    cur_timeout = ticks;
  endtask

  // Arm, hunt through a little noise, then send one reply of the given shape.
  task automatic send_reply(input int n, input reply_shape_t shape);
    logic [BYTE_W-1:0] sum;
    logic [BYTE_W-1:0] b;
    sum = '0;
    send_item(KIND_ARM, BYTE_W'($urandom));
    repeat ($urandom_range(0, 2)) begin
      b = BYTE_W'($urandom);
      if (b == ACK_BYTE || b == START_BYTE) b = b ^ 8'h01;
      if ($urandom_range(0, 1) == 0) send_item(KIND_TICK, BYTE_W'($urandom));
      else send_item(KIND_BYTE, b);
    end
    if (shape == REPLY_ACK) begin
      send_byte(ACK_BYTE);
      return;
    end
    send_byte(START_BYTE);
    send_byte(n[BYTE_W-1:0]);
    if (shape == REPLY_BAD_LENGTH) send_byte(n[BYTE_W-1:0] ^ (8'h01 << $urandom_range(0, 7)));
    else send_byte(n[BYTE_W-1:0]);
    b = BYTE_W'($urandom);
    if (b == START_BYTE) b = b ^ 8'h80;
    send_byte(shape == REPLY_BAD_START ? b : START_BYTE);
    if (shape == REPLY_SILENT) begin
      // go quiet and let the tick count run out
      repeat (cur_timeout + 1) send_item(KIND_TICK, BYTE_W'($urandom));
      return;
    end
    repeat (n) begin
      b = BYTE_W'($urandom);
      sum = sum + b;
      send_byte(b);
    end
    if (shape == REPLY_BAD_CHECKSUM) send_byte(sum ^ 8'($urandom_range(1, 255)));
    else send_byte(sum);
    b = BYTE_W'($urandom);
    if (b == STOP_BYTE) b = b ^ 8'h40;
    send_byte(shape == REPLY_BAD_STOP ? b : STOP_BYTE);
  endtask

  initial begin
    #(20_000_000);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    sb = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: idle items, ack after noise, re-arm into an empty frame,
    // length mismatch, checksum error.
    send_item(KIND_BYTE, START_BYTE);
    send_item(2'd3, 8'hFF);
    send_item(KIND_ARM, 8'h00);
    send_item(KIND_BYTE, 8'h00);
    send_item(KIND_BYTE, ACK_BYTE);
    send_item(KIND_ARM, 8'hFF);
    send_item(KIND_ARM, 8'h00);
    send_item(KIND_BYTE, START_BYTE);
    send_item(KIND_BYTE, 8'h00);
    send_item(KIND_BYTE, 8'h00);
    send_item(KIND_BYTE, START_BYTE);
    send_item(KIND_BYTE, 8'h00);
    send_item(KIND_BYTE, STOP_BYTE);
    send_item(KIND_ARM, 8'h00);
    send_item(KIND_BYTE, START_BYTE);
    send_item(KIND_BYTE, 8'h02);
    send_item(KIND_BYTE, 8'h03);
    send_item(KIND_ARM, 8'h00);
    send_item(KIND_BYTE, START_BYTE);
    send_item(KIND_BYTE, 8'h00);
    send_item(KIND_BYTE, 8'h00);
    send_item(KIND_BYTE, START_BYTE);
    send_item(KIND_BYTE, 8'hFF);

    phase = 0;
    while (sb.accepted_items < ITEM_TARGET) begin
      case (phase)
        0: configure(0, 1);
        1: configure(511, 1023);
        default: begin
          case ($urandom_range(0, 2))
            0: len = $urandom_range(0, 12);
            1: len = $urandom_range(0, 511);
            default: len = int'(BUFFER_LIMIT_RESET);
          endcase
          configure(len, ($urandom_range(0, 1) == 0) ? $urandom_range(1, 8)
                                                     : $urandom_range(1, 1023));
        end
      endcase
      if (phase == 1) begin
        // stall the result side while the sender keeps offering bytes
        hold_request = 1'b1;
        sender_calm = 1'b1;
        send_reply(24, REPLY_CLEAN);
        sender_calm = 1'b0;
        send_reply(255, REPLY_CLEAN);
      end
      repeat (8) begin
        sender_calm = ($urandom_range(0, 3) == 0);
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 12);
        case ($urandom_range(0, 9))
          4: send_reply(len, REPLY_BAD_LENGTH);
          5: send_reply(len, REPLY_BAD_START);
          6: send_reply(len, REPLY_BAD_CHECKSUM);
          7: send_reply(len, REPLY_BAD_STOP);
          8: send_reply(len, REPLY_ACK);
          9: send_reply(len, (cur_timeout <= 40) ? REPLY_SILENT : REPLY_CLEAN);
          default: send_reply(len, REPLY_CLEAN);
        endcase
        repeat ($urandom_range(0, 3)) begin
          send_item(KIND_W'($urandom_range(0, 3)), BYTE_W'($urandom));
        end
      end
      phase++;
    end

    // Short timeout, run out once; also puts the buffer limit back to reset.
    configure(int'(BUFFER_LIMIT_RESET), 12);
    send_reply(2, REPLY_SILENT);

    in_valid <= 1'b0;
    final_wait = 0;
    while (sb.pending() != 0 && final_wait < 5000) begin
      @(posedge clk);
      final_wait++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.pending() != 0) sb.report($sformatf("%0d results never arrived", sb.pending()));

    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== mbus_response_frame_receiver.f =====
src/mbus_rx_pkg.sv
src/mbus_rx_core.sv
src/mbus_response_frame_receiver.sv
src/mbus_rx_checker.sv
tb/mbus_reply_scoreboard.sv
tb/testbench.sv
